### hdl/sbfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the STX/ETX frame receiver with XOR check.
// No dependencies; every other file of the block imports this package.
package sbfr_pkg;

	localparam int CNT_W = 9;
	localparam int GAP_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

	localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 16'd50;
	localparam logic [7:0] STATION_ID_RST = 8'h01;
	localparam logic [7:0] PEER_ID_RST = 8'hff;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATION_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_ID = 2'd2;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_STORED = 3'd1,
		EV_DELIVERED = 3'd2,
		EV_BAD_HEADER = 3'd3,
		EV_CHECK_ERR = 3'd4,
		EV_BAD_ETX = 3'd5,
		EV_BUSY = 3'd6,
		EV_TIMEOUT = 3'd7
	} event_t;

	typedef struct packed {
		cmd_t cmd;
		logic [7:0] data_byte;
		logic [CNT_W-1:0] read_index;
	} rx_item_t;

	typedef struct packed {
		event_t event_code;
		logic [7:0] read_data;
		logic frame_ready;
		logic [CNT_W-1:0] frame_length;
		logic [CNT_W-1:0] partial_count;
	} res_item_t;

endpackage

### hdl/sbfr_bank_ram.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read byte memory holding both frame banks.
// Read data is registered and holds while no read is issued. Uses sbfr_pkg.
module sbfr_bank_ram
	import sbfr_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/stx_etx_bcc_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Top level of the STX/LEN/ETX frame receiver with XOR block check.
// Depends on sbfr_pkg and sbfr_bank_ram.
//
// Usage: each rx item carries a command (received byte, time tick, release of
// the delivered frame, or read of one delivered byte). Every accepted item
// produces exactly one res item with an event code, the read byte, the
// handoff status and the count of bytes held of the frame in progress.
// Received bytes are written into the current write bank of a two-bank
// memory; a good frame flips the bank when the consumer has released the
// previous one, otherwise it is dropped with a busy event.
// The result of an item is registered and presented in the cycle after it is
// accepted; the read byte comes straight from the registered memory output.
// Throughput: one item per cycle while rx_stall is low, set by the single state
// update and the at most one memory access (write or read) that each item makes.
// Stall: rx_stall is high while a result waits and res_stall is high; the
// pending result and the memory read data hold until taken.
// Reset: arst_n clears the parse state, the handoff, the tick counter and the
// registers to their defaults. The memory is not cleared; only bytes of a
// delivered frame are ever read. The cfg port takes writes at any edge.
module stx_etx_bcc_frame_receiver_unit
	import sbfr_pkg::*;
#(
	parameter int FRAME_BYTES = 512
) (
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	output logic rx_stall,
	input rx_item_t rx_item,
	output logic res_valid,
	input logic res_stall,
	output res_item_t res_item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	localparam int DEPTH = 2 * FRAME_BYTES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] BANK_OFS = AW'(FRAME_BYTES);
	localparam logic [CNT_W+1:0] FRAME_LIM = (CNT_W+2)'(FRAME_BYTES);

	logic [GAP_W-1:0] gap_limit_q;
	logic [7:0] station_id_q;
	logic [7:0] peer_id_q;

	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [CNT_W-1:0] end_pos_q, end_pos_d;
	logic [7:0] check_q, check_d;
	logic bank_q, bank_d;
	logic full_q, full_d;
	logic [CNT_W-1:0] hlen_q, hlen_d;
	logic [GAP_W-1:0] gap_q, gap_d;

	logic accept;
	logic mem_we, mem_re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] rdata;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] cnt_new;
	logic timed_out;
	event_t ev;

	logic valid_q;
	event_t ev_s1;
	logic rd_en_s1;
	logic ready_s1;
	logic [CNT_W-1:0] flen_s1;
	logic [CNT_W-1:0] part_s1;

	assign rx_stall = valid_q && res_stall;
	assign accept = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
			station_id_q <= STATION_ID_RST;
			peer_id_q <= PEER_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAP_LIMIT: gap_limit_q <= cfg_data;
				REG_STATION_ID: station_id_q <= cfg_data[7:0];
				REG_PEER_ID: peer_id_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		byte_count_d = byte_count_q;
		end_pos_d = end_pos_q;
		check_d = check_q;
		bank_d = bank_q;
		full_d = full_q;
		hlen_d = hlen_q;
		gap_d = gap_q;
		ev = EV_NONE;
		mem_we = 1'b0;
		mem_re = 1'b0;
		timed_out = 1'b0;
		pos = byte_count_q;
		cnt_new = byte_count_q + CNT_W'(1);

		unique case (rx_item.cmd)
			CMD_BYTE: begin
				if (byte_count_q != '0 && gap_q >= gap_limit_q) begin
					timed_out = 1'b1;
					pos = '0;
				end
				gap_d = '0;
				cnt_new = pos + CNT_W'(1);
				mem_we = {2'b00, pos} < FRAME_LIM;
				byte_count_d = cnt_new;
				ev = EV_STORED;
				if (cnt_new == CNT_W'(1)) begin
					if (rx_item.data_byte != STX_BYTE) begin
						byte_count_d = '0;
						ev = EV_BAD_HEADER;
					end
				end else if (cnt_new == CNT_W'(2)) begin
					if (rx_item.data_byte != station_id_q) begin
						byte_count_d = '0;
						ev = EV_BAD_HEADER;
					end else begin
						check_d = station_id_q;
					end
				end else if (cnt_new == CNT_W'(3)) begin
					if (rx_item.data_byte != peer_id_q) begin
						byte_count_d = '0;
						ev = EV_BAD_HEADER;
					end else begin
						check_d = check_q ^ rx_item.data_byte;
					end
				end else if (cnt_new == CNT_W'(4)) begin
					check_d = check_q ^ rx_item.data_byte;
					end_pos_d = CNT_W'(5) + CNT_W'(rx_item.data_byte);
				end else if (cnt_new == end_pos_q) begin
					if (check_q != rx_item.data_byte) begin
						byte_count_d = '0;
						ev = EV_CHECK_ERR;
					end
				end else if (cnt_new == end_pos_q + CNT_W'(1)) begin
					byte_count_d = '0;
					if (rx_item.data_byte != ETX_BYTE) begin
						ev = EV_BAD_ETX;
					end else if (full_q) begin
						ev = EV_BUSY;
					end else begin
						full_d = 1'b1;
						hlen_d = cnt_new;
						bank_d = !bank_q;
						ev = EV_DELIVERED;
					end
				end else begin
					check_d = check_q ^ rx_item.data_byte;
				end
				if ({2'b00, byte_count_d} >= FRAME_LIM) begin
					byte_count_d = '0;
				end
				if (timed_out) begin
					ev = EV_TIMEOUT;
				end
			end
			CMD_TICK: begin
				if (gap_q != GAP_MAX) begin
					gap_d = gap_q + GAP_W'(1);
				end
			end
			CMD_RELEASE: begin
				full_d = 1'b0;
			end
			CMD_READ: begin
				mem_re = full_q && (rx_item.read_index < hlen_q);
			end
			default: ;
		endcase
	end

	assign waddr = (bank_q ? BANK_OFS : '0) + AW'(pos);
	assign raddr = (bank_q ? '0 : BANK_OFS) + AW'(rx_item.read_index);

	sbfr_bank_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(accept && mem_we),
		.waddr(waddr),
		.wdata(rx_item.data_byte),
		.re(accept && mem_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			end_pos_q <= '0;
			check_q <= '0;
			bank_q <= 1'b0;
			full_q <= 1'b0;
			hlen_q <= '0;
			gap_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				byte_count_q <= byte_count_d;
				end_pos_q <= end_pos_d;
				check_q <= check_d;
				bank_q <= bank_d;
				full_q <= full_d;
				hlen_q <= hlen_d;
				gap_q <= gap_d;
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev;
			rd_en_s1 <= mem_re;
			ready_s1 <= full_d;
			flen_s1 <= full_d ? hlen_d : '0;
			part_s1 <= byte_count_d;
		end
	end

	assign res_valid = valid_q;

	always_comb begin
		res_item.event_code = ev_s1;
		res_item.read_data = rd_en_s1 ? rdata : 8'h00;
		res_item.frame_ready = ready_s1;
		res_item.frame_length = flen_s1;
		res_item.partial_count = part_s1;
	end

endmodule
